@@ rtl/paused_rr_qp_arbiter_top_assert.svh @@
// Assertion macros for the queue-pair arbiter checker.
`ifndef PAUSED_RR_QP_ARBITER_TOP_ASSERT_SVH
`define PAUSED_RR_QP_ARBITER_TOP_ASSERT_SVH

// Checked outside reset only.
`define PRQA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define PRQA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/prqa_pkg.sv @@
// Shared constants and types for the queue-pair arbiter.
package prqa_pkg;

  localparam int MAX_QPS       = 64;
  localparam int NUM_CLASSES   = 8;
  localparam int QP_W          = $clog2(MAX_QPS);
  localparam int CNT_W         = $clog2(MAX_QPS + 1);
  localparam int CLASS_W       = 3;
  localparam int TIME_W        = 32;
  localparam int ACTIVE_W      = 7;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 7;
  localparam int GRANT_INDEX_W = 6;

  localparam logic [CLASS_W-1:0] ACK_CLASS_RESET = 3'd3;

  localparam logic [1:0] MODE_WRITE   = 2'd0;
  localparam logic [1:0] MODE_PAUSE   = 2'd1;
  localparam logic [1:0] MODE_REQUEST = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_QPS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACK_CLASS  = 2'd1;

  typedef enum logic [1:0] {
    GK_NONE = 2'd0,
    GK_ACK  = 2'd1,
    GK_QP   = 2'd2
  } grant_kind_t;

  typedef struct packed {
    logic [CLASS_W-1:0] cls;
    logic               bytes;
    logic               wbound;
    logic               done;
    logic [TIME_W-1:0]  avail;
  } qp_entry_t;

  localparam int ENTRY_W = $bits(qp_entry_t);

endpackage

@@ rtl/prqa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module prqa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/paused_rr_qp_arbiter_top.sv @@
// Egress arbiter: strict-priority ack queue over a round-robin queue-pair table.
//
// Request channel (req_valid / req_stall): one word per item, selected by mode:
// write a table entry, pause or resume a class, or request a grant. Write and
// pause words are taken with no stall and give no result. A request stalls the
// channel until its result is registered on the grant channel.
// Grant channel (gnt_valid / gnt_stall): one word per request, grant_kind and
// grant_index. The output register holds while a valid word is stalled; table
// and pause words are still taken during that time.
// A request that the ack queue wins, or that finds no entry active, skips the
// scan. Otherwise the round-robin start (pointer + 1) is reduced into range by
// repeated subtraction (needed when the pointer sits on the last active entry,
// more than once only after active_qps was lowered below the pointer), then at
// most active_qps entries (capped at 64) are scanned, one table read per cycle
// through the single read port. The result then goes into the output register.
// Configuration (cfg_valid / cfg_ready): always ready; to be written only while
// idle, which the block itself does not enforce.
// Reset (rst, synchronous): pointer to zero, all classes unpaused, active_qps
// zero, ack_class 3, output empty. Table contents stay undefined until written.
module paused_rr_qp_arbiter_top
  import prqa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  logic [1:0]            mode,
  input  logic [5:0]            qp_index,
  input  logic [2:0]            prio_class,
  input  logic                  has_bytes,
  input  logic                  window_bound,
  input  logic                  done_flag,
  input  logic [31:0]           avail_time,
  input  logic [2:0]            pause_target,
  input  logic                  pause_on,
  input  logic                  ack_pending,
  input  logic [31:0]           now_time,
  output logic                  gnt_valid,
  input  logic                  gnt_stall,
  output logic [1:0]            grant_kind,
  output logic [5:0]            grant_index,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MOD  = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_HOLD = 4'b1000
  } state_t;

  function automatic logic class_paused(input logic [NUM_CLASSES-1:0] mask,
                                        input logic [CLASS_W-1:0] c);
    logic p;
    p = 1'b0;
    for (int i = 0; i < NUM_CLASSES; i++) begin
      if (32'(c) == i) p = mask[i];
    end
    return p;
  endfunction

  state_t                 state, state_next;
  logic [QP_W-1:0]        rr_pointer, rr_pointer_next;
  logic [NUM_CLASSES-1:0] pause_mask, pause_mask_next;
  logic [ACTIVE_W-1:0]    active_qps;
  logic [CLASS_W-1:0]     ack_class;
  logic [CNT_W-1:0]       mod_val, mod_val_next;
  logic [QP_W-1:0]        cur, cur_next;
  logic [CNT_W-1:0]       issued, issued_next;
  logic [CNT_W-1:0]       checked, checked_next;
  logic                   rd_vld, rd_vld_next;
  logic [QP_W-1:0]        rd_idx, rd_idx_next;
  logic [TIME_W-1:0]      now_q, now_q_next;
  grant_kind_t            res_kind, res_kind_next;
  logic [QP_W-1:0]        res_index, res_index_next;
  logic                   gnt_valid_next;
  logic [1:0]             grant_kind_next;
  logic [5:0]             grant_index_next;

  logic [CNT_W-1:0]       n_act;
  logic                   ram_we, ram_re;
  logic [ENTRY_W-1:0]     ram_wdata, ram_rdata;
  qp_entry_t              wr_entry, rd_entry;
  logic                   eligible;

  assign cfg_ready = 1'b1;
  assign req_stall = (state != ST_IDLE);

  // entries taking part, saturated to the table size
  always_comb begin
    if (32'(active_qps) > MAX_QPS) n_act = CNT_W'(MAX_QPS);
    else                           n_act = CNT_W'(active_qps);
  end

  assign wr_entry  = '{cls: prio_class, bytes: has_bytes, wbound: window_bound,
                       done: done_flag, avail: avail_time};
  assign ram_wdata = wr_entry;
  assign rd_entry  = qp_entry_t'(ram_rdata);
  assign eligible  = !class_paused(pause_mask, rd_entry.cls) && rd_entry.bytes &&
                     !rd_entry.wbound && !rd_entry.done && !(rd_entry.avail > now_q);

  prqa_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MAX_QPS)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(QP_W'(qp_index)),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(cur),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_next       = state;
    rr_pointer_next  = rr_pointer;
    pause_mask_next  = pause_mask;
    mod_val_next     = mod_val;
    cur_next         = cur;
    issued_next      = issued;
    checked_next     = checked;
    rd_vld_next      = 1'b0;
    rd_idx_next      = cur;
    now_q_next       = now_q;
    res_kind_next    = res_kind;
    res_index_next   = res_index;
    gnt_valid_next   = gnt_valid && gnt_stall;
    grant_kind_next  = grant_kind;
    grant_index_next = grant_index;
    ram_we           = 1'b0;
    ram_re           = 1'b0;

    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          case (mode)
            MODE_WRITE: begin
              ram_we = (32'(qp_index) < MAX_QPS);
            end
            MODE_PAUSE: begin
              for (int i = 0; i < NUM_CLASSES; i++) begin
                if (32'(pause_target) == i) pause_mask_next[i] = pause_on;
              end
            end
            MODE_REQUEST: begin
              now_q_next     = now_time;
              res_index_next = '0;
              if (ack_pending && !class_paused(pause_mask, ack_class)) begin
                res_kind_next = GK_ACK;
                state_next    = ST_HOLD;
              end else if (n_act == '0) begin
                res_kind_next = GK_NONE;
                state_next    = ST_HOLD;
              end else begin
                mod_val_next = CNT_W'(rr_pointer) + 1'b1;
                state_next   = ST_MOD;
              end
            end
            default: ;
          endcase
        end
      end

      // start index = (pointer + 1) mod n by repeated subtraction
      ST_MOD: begin
        if (mod_val >= n_act) begin
          mod_val_next = mod_val - n_act;
        end else begin
          cur_next     = mod_val[QP_W-1:0];
          issued_next  = '0;
          checked_next = '0;
          state_next   = ST_SCAN;
        end
      end

      // one read issued per cycle; data checked in the cycle after the read
      ST_SCAN: begin
        if (issued != n_act) begin
          ram_re      = 1'b1;
          rd_vld_next = 1'b1;
          rd_idx_next = cur;
          issued_next = issued + 1'b1;
          if (CNT_W'(cur) + 1'b1 == n_act) cur_next = '0;
          else                             cur_next = cur + 1'b1;
        end
        if (rd_vld) begin
          if (eligible) begin
            res_kind_next   = GK_QP;
            res_index_next  = rd_idx;
            rr_pointer_next = rd_idx;
            rd_vld_next     = 1'b0;
            state_next      = ST_HOLD;
          end else if (checked + 1'b1 == n_act) begin
            res_kind_next  = GK_NONE;
            res_index_next = '0;
            state_next     = ST_HOLD;
          end else begin
            checked_next = checked + 1'b1;
          end
        end
      end

      ST_HOLD: begin
        if (!gnt_valid || !gnt_stall) begin
          gnt_valid_next   = 1'b1;
          grant_kind_next  = res_kind;
          grant_index_next = GRANT_INDEX_W'(res_index);
          state_next       = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      rr_pointer <= '0;
      pause_mask <= '0;
      active_qps <= '0;
      ack_class  <= ACK_CLASS_RESET;
      rd_vld     <= 1'b0;
      gnt_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      rr_pointer <= rr_pointer_next;
      pause_mask <= pause_mask_next;
      rd_vld     <= rd_vld_next;
      gnt_valid  <= gnt_valid_next;
      if (cfg_valid) begin
        case (cfg_index)
          REG_ACTIVE_QPS: active_qps <= cfg_data[ACTIVE_W-1:0];
          REG_ACK_CLASS:  ack_class  <= cfg_data[CLASS_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    mod_val     <= mod_val_next;
    cur         <= cur_next;
    issued      <= issued_next;
    checked     <= checked_next;
    rd_idx      <= rd_idx_next;
    now_q       <= now_q_next;
    res_kind    <= res_kind_next;
    res_index   <= res_index_next;
    grant_kind  <= grant_kind_next;
    grant_index <= grant_index_next;
  end

endmodule

@@ rtl/prqa_checker.sv @@
// Port-level checker for the queue-pair arbiter, bound to the top level.
`include "paused_rr_qp_arbiter_top_assert.svh"

module prqa_checker
  import prqa_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_stall,
  input logic [1:0] mode,
  input logic       gnt_valid,
  input logic       gnt_stall,
  input logic [1:0] grant_kind,
  input logic [5:0] grant_index
);

  logic       req_take;
  logic       is_req;
  logic       gnt_held;
  logic       not_qp;
  logic [7:0] gnt_word;

  assign req_take = req_valid && !req_stall;
  assign is_req   = (mode == MODE_REQUEST);
  assign gnt_held = gnt_valid && gnt_stall;
  assign not_qp   = gnt_valid && (grant_kind != GK_QP);
  assign gnt_word = {grant_kind, grant_index};

  `PRQA_ASSERT_ALWAYS(a_reset_empties_output, rst |=> !gnt_valid, "output valid after reset")

  `PRQA_ASSERT(a_index_zero_unless_qp, not_qp |-> grant_index == '0, "stray grant_index")

  `PRQA_ASSERT(a_request_blocks, req_take && is_req |=> req_stall, "request word not held off")

  `PRQA_ASSERT(a_update_no_block, req_take && !is_req |=> !req_stall, "update word stalled")

  `PRQA_ASSERT(a_grant_holds, gnt_held |=> gnt_valid && $stable(gnt_word), "stalled word changed")

endmodule

bind paused_rr_qp_arbiter_top prqa_checker u_prqa_checker (.*);

@@ tb/tb.sv @@
// Self-checking testbench for the queue-pair egress arbiter.
`timescale 1ns / 1ps

module tb;
  import prqa_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int NUM_DIR       = 30;
  localparam int NUM_PHASES    = 8;
  localparam int PHASE_ITEMS   = 205;
  localparam int SETTLE_CYCLES = 140;
  localparam int CYCLE_LIMIT   = 2_000_000;

  typedef struct {
    logic [1:0]  mode;
    logic [5:0]  qp;
    logic [2:0]  cls;
    logic        bytes;
    logic        wb;
    logic        done;
    logic [31:0] avail;
    logic [2:0]  ptgt;
    logic        pon;
    logic        ack;
    logic [31:0] now;
  } req_word_t;

  typedef struct {
    grant_kind_t kind;
    logic [5:0]  idx;
  } grant_t;

  typedef struct {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_val;
    req_word_t             w;
    bit                    typed;
    grant_t                g;
  } dir_row_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  req_valid = 1'b0;
  logic                  req_stall;
  logic [1:0]            mode = '0;
  logic [5:0]            qp_index = '0;
  logic [2:0]            prio_class = '0;
  logic                  has_bytes = 1'b0;
  logic                  window_bound = 1'b0;
  logic                  done_flag = 1'b0;
  logic [31:0]           avail_time = '0;
  logic [2:0]            pause_target = '0;
  logic                  pause_on = 1'b0;
  logic                  ack_pending = 1'b0;
  logic [31:0]           now_time = '0;
  logic                  gnt_valid;
  logic                  gnt_stall = 1'b0;
  logic [1:0]            grant_kind;
  logic [5:0]            grant_index;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  paused_rr_qp_arbiter_top dut (.*);

  // arbiter state as predicted
  qp_entry_t        qp_tab [MAX_QPS];
  logic [7:0]       held_classes = '0;
  int unsigned      rr_ptr = 0;
  int unsigned      act_qps = 0;
  logic [2:0]       ack_cls = ACK_CLASS_RESET;

  grant_t           grants_due [$];
  int               errs = 0;
  int               n_wr = 0, n_ps = 0, n_rq = 0, n_regs = 0;
  int               n_ack = 0, n_qp = 0, n_none = 0;
  int               send_idle_pct = 0;
  int               stall_pct = 0;
  logic [31:0]      cur_now = 32'd1000;
  longint           cycles = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    gnt_stall <= !rst && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    grant_t exp_g;
    if (!rst && gnt_valid && !gnt_stall) begin
      if (grants_due.size() == 0) begin
        $error("grant word with nothing outstanding: kind %0d index %0d",
               grant_kind, grant_index);
        errs++;
      end else begin
        exp_g = grants_due.pop_front();
        if (grant_kind !== exp_g.kind) begin
          $error("grant_kind: expected %0d, got %0d", exp_g.kind, grant_kind);
          errs++;
        end
        if (grant_index !== exp_g.idx) begin
          $error("grant_index: expected %0d, got %0d", exp_g.idx, grant_index);
          errs++;
        end
        case (exp_g.kind)
          GK_ACK:  n_ack++;
          GK_QP:   n_qp++;
          default: n_none++;
        endcase
      end
    end
  end

  function automatic grant_t arbitrate(input logic ack, input logic [31:0] now);
    grant_t      g;
    int unsigned n;
    int unsigned idx;
    qp_entry_t   e;
    g.kind = GK_NONE;
    g.idx  = '0;
    if (ack && !held_classes[ack_cls]) begin
      g.kind = GK_ACK;
      return g;
    end
    n = (act_qps > MAX_QPS) ? MAX_QPS : act_qps;
    for (int unsigned k = 1; k <= n; k++) begin
      idx = (k + rr_ptr) % n;
      e = qp_tab[idx];
      if (!held_classes[e.cls] && e.bytes && !e.wbound && !e.done && e.avail <= now) begin
        rr_ptr = idx;
        g.kind = GK_QP;
        g.idx  = idx[5:0];
        return g;
      end
    end
    return g;
  endfunction

  task automatic send_word(input req_word_t w, input bit typed, input grant_t tg);
    grant_t g;
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid    <= 1'b1;
    mode         <= w.mode;
    qp_index     <= w.qp;
    prio_class   <= w.cls;
    has_bytes    <= w.bytes;
    window_bound <= w.wb;
    done_flag    <= w.done;
    avail_time   <= w.avail;
    pause_target <= w.ptgt;
    pause_on     <= w.pon;
    ack_pending  <= w.ack;
    now_time     <= w.now;
    do @(posedge clk); while (req_stall);
    case (w.mode)
      MODE_WRITE: begin
        qp_tab[w.qp].cls    = w.cls;
        qp_tab[w.qp].bytes  = w.bytes;
        qp_tab[w.qp].wbound = w.wb;
        qp_tab[w.qp].done   = w.done;
        qp_tab[w.qp].avail  = w.avail;
        n_wr++;
      end
      MODE_PAUSE: begin
        held_classes[w.ptgt] = w.pon;
        n_ps++;
      end
      MODE_REQUEST: begin
        g = arbitrate(w.ack, w.now);
        grants_due.push_back(typed ? tg : g);
        n_rq++;
      end
      default: ;
    endcase
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    while (grants_due.size() != 0) @(posedge clk);
  endtask

  // table and pause words give no result, so allow for a scan still running
  task automatic settle();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] ri, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= ri;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (ri)
      REG_ACTIVE_QPS: act_qps = 32'(val);
      REG_ACK_CLASS:  ack_cls = val[2:0];
      default: ;
    endcase
    n_regs++;
    @(posedge clk);
  endtask

  function automatic dir_row_t base_row();
    dir_row_t r;
    r.is_cfg  = 1'b0;
    r.cfg_idx = '0;
    r.cfg_val = '0;
    r.w       = '{default: '0};
    r.typed   = 1'b0;
    r.g.kind  = GK_NONE;
    r.g.idx   = '0;
    return r;
  endfunction

  function automatic dir_row_t row_wr(input logic [5:0] qp, input logic [2:0] cls,
                                      input logic bytes, input logic wb, input logic done,
                                      input logic [31:0] avail);
    dir_row_t r = base_row();
    r.w.mode  = MODE_WRITE;
    r.w.qp    = qp;
    r.w.cls   = cls;
    r.w.bytes = bytes;
    r.w.wb    = wb;
    r.w.done  = done;
    r.w.avail = avail;
    return r;
  endfunction

  function automatic dir_row_t row_pause(input logic [2:0] tgt, input logic on);
    dir_row_t r = base_row();
    r.w.mode = MODE_PAUSE;
    r.w.ptgt = tgt;
    r.w.pon  = on;
    return r;
  endfunction

  function automatic dir_row_t row_req(input logic ack, input logic [31:0] now,
                                       input bit typed, input grant_kind_t k,
                                       input logic [5:0] gi);
    dir_row_t r = base_row();
    r.w.mode = MODE_REQUEST;
    r.w.ack  = ack;
    r.w.now  = now;
    r.typed  = typed;
    r.g.kind = k;
    r.g.idx  = gi;
    return r;
  endfunction

  function automatic dir_row_t row_reg(input logic [CFG_IDX_W-1:0] ri,
                                       input logic [CFG_DATA_W-1:0] val);
    dir_row_t r = base_row();
    r.is_cfg  = 1'b1;
    r.cfg_idx = ri;
    r.cfg_val = val;
    return r;
  endfunction

  function automatic req_word_t random_word();
    req_word_t w;
    int        pick;
    w = '{default: '0};
    pick = $urandom_range(99);
    w.qp    = 6'($urandom_range(63));
    w.cls   = 3'($urandom_range(7));
    w.bytes = ($urandom_range(9) != 0);
    w.wb    = ($urandom_range(5) == 0);
    w.done  = ($urandom_range(9) == 0);
    case ($urandom_range(19))
      0:       w.avail = '0;
      1:       w.avail = '1;
      2:       w.avail = $urandom;
      default: w.avail = cur_now + $urandom_range(24) - 16;
    endcase
    w.ptgt = 3'($urandom_range(7));
    w.pon  = ($urandom_range(9) < 4);
    w.ack  = ($urandom_range(3) == 0);
    case ($urandom_range(19))
      0:       w.now = $urandom;
      1:       w.now = '1;
      default: w.now = cur_now;
    endcase
    cur_now = cur_now + $urandom_range(4);
    if (pick < 5)       w.mode = MODE_UNUSED;
    else if (pick < 40) w.mode = MODE_WRITE;
    else if (pick < 52) w.mode = MODE_PAUSE;
    else                w.mode = MODE_REQUEST;
    return w;
  endfunction

  initial begin
    dir_row_t  dir_rows [NUM_DIR];
    req_word_t w;
    grant_t    no_grant;
    int        act_plan [NUM_PHASES] = '{64, 127, 1, 2, 37, 0, 64, 5};
    int        ack_plan [NUM_PHASES] = '{0, 7, 3, 5, 1, 6, 2, 4};
    int        idle_plan [4] = '{0, 46, 0, 38};
    int        stall_plan [4] = '{0, 0, 46, 38};
    int        i;

    no_grant.kind = GK_NONE;
    no_grant.idx  = '0;
    foreach (qp_tab[q]) qp_tab[q] = '0;

    dir_rows = '{
      row_req(1'b0, 32'h0, 1'b1, GK_NONE, 6'd0),
      row_req(1'b1, 32'hffff_ffff, 1'b1, GK_ACK, 6'd0),
      row_pause(3'd3, 1'b1),
      row_req(1'b1, 32'h0000_1234, 1'b1, GK_NONE, 6'd0),
      row_wr(6'd63, 3'd7, 1'b1, 1'b1, 1'b1, 32'hffff_ffff),
      row_wr(6'd0, 3'd0, 1'b1, 1'b0, 1'b0, 32'h0),
      row_wr(6'd1, 3'd7, 1'b1, 1'b0, 1'b0, 32'hffff_ffff),
      row_wr(6'd2, 3'd3, 1'b1, 1'b0, 1'b0, 32'h0),
      row_wr(6'd3, 3'd5, 1'b1, 1'b1, 1'b0, 32'h0),
      row_wr(6'd63, 3'd2, 1'b1, 1'b0, 1'b1, 32'd5),
      row_reg(REG_ACTIVE_QPS, 7'd4),
      row_req(1'b0, 32'h0, 1'b1, GK_QP, 6'd0),
      row_req(1'b0, 32'hffff_ffff, 1'b0, GK_NONE, 6'd0),
      row_pause(3'd3, 1'b0),
      row_req(1'b0, 32'd10, 1'b0, GK_NONE, 6'd0),
      row_wr(6'd0, 3'd0, 1'b1, 1'b0, 1'b1, 32'h0),
      row_req(1'b0, 32'd10, 1'b0, GK_NONE, 6'd0),
      row_reg(REG_ACK_CLASS, 7'd7),
      row_pause(3'd7, 1'b1),
      row_req(1'b1, 32'd10, 1'b0, GK_NONE, 6'd0),
      row_reg(REG_ACTIVE_QPS, 7'd1),
      row_req(1'b0, 32'h0, 1'b1, GK_NONE, 6'd0),
      row_wr(6'd0, 3'd0, 1'b1, 1'b0, 1'b0, 32'h0),
      row_req(1'b0, 32'h0, 1'b0, GK_NONE, 6'd0),
      row_reg(REG_ACK_CLASS, 7'd0),
      row_pause(3'd0, 1'b1),
      row_req(1'b1, 32'h0, 1'b0, GK_NONE, 6'd0),
      row_pause(3'd7, 1'b0),
      row_pause(3'd0, 1'b0),
      row_req(1'b1, 32'h0, 1'b1, GK_ACK, 6'd0)
    };
    // row 4 becomes the unused mode code with every other field at its top value
    dir_rows[4].w.mode = MODE_UNUSED;
    dir_rows[4].w.ptgt = '1;
    dir_rows[4].w.pon  = 1'b1;
    dir_rows[4].w.ack  = 1'b1;
    dir_rows[4].w.now  = '1;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[r]) begin
      if (dir_rows[r].is_cfg) begin
        settle();
        write_reg(dir_rows[r].cfg_idx, dir_rows[r].cfg_val);
      end else begin
        send_word(dir_rows[r].w, dir_rows[r].typed, dir_rows[r].g);
      end
    end

    // fill the whole table before any larger active count is set
    for (int q = 0; q < MAX_QPS; q++) begin
      w = random_word();
      w.mode = MODE_WRITE;
      w.qp   = 6'(q);
      send_word(w, 1'b0, no_grant);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      write_reg(REG_ACTIVE_QPS, CFG_DATA_W'(act_plan[p]));
      write_reg(REG_ACK_CLASS, CFG_DATA_W'(ack_plan[p]));
      send_idle_pct = idle_plan[p % 4];
      stall_pct     = stall_plan[p % 4];
      i = 0;
      while (i < PHASE_ITEMS) begin
        if (i == PHASE_ITEMS / 2) drain();
        w = random_word();
        send_word(w, 1'b0, no_grant);
        if (w.mode != MODE_UNUSED) i++;
      end
    end

    settle();
    $display("covered %0d table writes, %0d pause words, %0d requests over %0d register writes",
             n_wr, n_ps, n_rq, n_regs);
    $display("grants checked: %0d ack, %0d queue pair, %0d empty", n_ack, n_qp, n_none);
    if (errs == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/prqa_pkg.sv
rtl/prqa_ram.sv
rtl/paused_rr_qp_arbiter_top.sv
rtl/prqa_checker.sv
tb/tb.sv
